### rtl/pal_pkg.sv
// ----------------------------------------------------------------------------
// pal_pkg
// Shared types, codes and constants for the positional array list.
// ----------------------------------------------------------------------------
`default_nettype none

package pal_pkg;

  // default list capacity
  localparam int CAPACITY_DEFAULT = 16;

  // field widths
  localparam int OPCODE_W = 2;
  localparam int POS_W    = 16;
  localparam int DATA_W   = 32;
  localparam int STATUS_W = 3;
  localparam int FIDX_W   = 4;
  localparam int LEN_W    = 5;

  // request opcodes
  typedef enum logic [OPCODE_W-1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_FIND   = 2'd2,
    OP_READ   = 2'd3
  } op_t;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    STAT_OK       = 3'd0,
    STAT_FULL     = 3'd1,
    STAT_EMPTY    = 3'd2,
    STAT_BADPOS   = 3'd3,
    STAT_NOTFOUND = 3'd4
  } status_t;

  // input transaction
  typedef struct packed {
    logic [OPCODE_W-1:0]      opcode;
    logic [POS_W-1:0]         position;
    logic signed [DATA_W-1:0] value;
  } pal_in_t;

  // output transaction
  typedef struct packed {
    logic [STATUS_W-1:0]      status;
    logic [FIDX_W-1:0]        found_index;
    logic signed [DATA_W-1:0] read_value;
    logic [LEN_W-1:0]         length;
  } pal_out_t;

  // broadcast control for the cell row
  typedef struct packed {
    logic              ins;    // insert: open a gap at idx
    logic              del;    // delete: close the gap at idx
    logic [POS_W-1:0]  idx;    // 0-based target index
    logic [DATA_W-1:0] value;  // value to load or compare
  } pal_cell_ctrl_t;

endpackage

`default_nettype wire

### rtl/positional_array_list_top.sv
// ----------------------------------------------------------------------------
// positional_array_list_top
// Ordered list of signed 32-bit elements with insert, delete, find and
// read by position, held in a shifting row of cells.
// ----------------------------------------------------------------------------
// An input transaction is captured, then executed once the output register
// can take the result. The capture/execute sequencer holds one request at a
// time, and all cells shift or compare in parallel.
// A waiting result sits in the output register while the next request is
// taken. Reset empties the list (count to zero); cell contents are not reset.
`default_nettype none

module positional_array_list_top
  import pal_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEFAULT
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire pal_in_t  in_data,
  output logic          out_valid,
  input  wire logic     out_ready,
  output pal_out_t      out_data
);

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(CAPACITY);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } state_t;

  state_t            state, state_next;
  pal_in_t           req;
  logic [CNT_W-1:0]  count, count_next;
  pal_out_t          res_next;
  pal_cell_ctrl_t    ctrl;
  logic              exec_go;

  logic [CAPACITY-1:0][DATA_W-1:0] cell_data;
  logic [CAPACITY-1:0]             cell_match;

  // sequencer
  assign in_ready = (state == ST_IDLE);
  assign exec_go  = (state == ST_EXEC) && (!out_valid || out_ready);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_EXEC;
      end
      ST_EXEC: begin
        if (exec_go) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // request capture
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req <= in_data;
    end
  end

  // position checks
  logic [POS_W:0]   cnt_ext;
  logic [POS_W:0]   pos_ext;
  logic [POS_W-1:0] pos_m1;
  logic [IDX_W-1:0] rd_idx;
  logic             list_full, list_empty, pos_in_list, pos_in_ins;

  assign cnt_ext     = (POS_W + 1)'(count);
  assign pos_ext     = {1'b0, req.position};
  assign pos_m1      = req.position - POS_W'(1);
  assign rd_idx      = pos_m1[IDX_W-1:0];
  assign list_full   = (count == CNT_MAX);
  assign list_empty  = (count == '0);
  assign pos_in_list = (req.position != '0) && (pos_ext <= cnt_ext);
  assign pos_in_ins  = (req.position != '0) && (pos_ext <= cnt_ext + (POS_W + 1)'(1));

  // first match among live entries
  logic             hit;
  logic [FIDX_W-1:0] hit_idx;

  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (cell_match[i] && (CNT_W'(i) < count)) begin
        hit     = 1'b1;
        hit_idx = FIDX_W'(i);
      end
    end
  end

  // operation decode and result
  always_comb begin
    count_next           = count;
    ctrl.ins             = 1'b0;
    ctrl.del             = 1'b0;
    ctrl.idx             = pos_m1;
    ctrl.value           = req.value;
    res_next.status      = STAT_OK;
    res_next.found_index = '0;
    res_next.read_value  = '0;
    case (op_t'(req.opcode))
      OP_INSERT: begin
        if (list_full) begin
          res_next.status = STAT_FULL;
        end else if (!pos_in_ins) begin
          res_next.status = STAT_BADPOS;
        end else begin
          ctrl.ins   = exec_go;
          count_next = count + CNT_W'(1);
        end
      end
      OP_DELETE: begin
        if (list_empty) begin
          res_next.status = STAT_EMPTY;
        end else if (!pos_in_list) begin
          res_next.status = STAT_BADPOS;
        end else begin
          ctrl.del   = exec_go;
          count_next = count - CNT_W'(1);
        end
      end
      OP_FIND: begin
        if (hit) begin
          res_next.found_index = hit_idx;
        end else begin
          res_next.status = STAT_NOTFOUND;
        end
      end
      OP_READ: begin
        if (list_empty) begin
          res_next.status = STAT_EMPTY;
        end else if (!pos_in_list) begin
          res_next.status = STAT_BADPOS;
        end else begin
          res_next.read_value = cell_data[rd_idx];
        end
      end
      default: res_next.status = STAT_OK;
    endcase
    res_next.length = LEN_W'(count_next);
  end

  // cell row
  pal_chain #(
    .CAPACITY (CAPACITY)
  ) u_chain (
    .clk   (clk),
    .ctrl  (ctrl),
    .data  (cell_data),
    .match (cell_match)
  );

  // entry count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (exec_go) begin
      count <= count_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (exec_go) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_go) begin
      out_data <= res_next;
    end
  end

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_MAX)
    else $error("entry count above capacity");

  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == ST_EXEC))
    else $error("accepted transaction not executed");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    !exec_go |=> $stable(count))
    else $error("count changed without an executing transaction");

  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_EXEC))
    else $error("result produced without an executing transaction");

endmodule

`default_nettype wire

### rtl/pal_cell.sv
// ----------------------------------------------------------------------------
// pal_cell
// One list slot: holds an element, takes its left or right neighbor on
// a shift, loads a new value on insert and compares against the key.
// ----------------------------------------------------------------------------
`default_nettype none

module pal_cell
  import pal_pkg::*;
#(
  parameter int INDEX = 0
) (
  input  wire logic                  clk,
  input  wire pal_cell_ctrl_t        ctrl,
  input  wire logic [DATA_W-1:0]     left_data,
  input  wire logic [DATA_W-1:0]     right_data,
  output logic      [DATA_W-1:0]     data,
  output logic                       match
);

  localparam logic [POS_W-1:0] MY_IDX = POS_W'(INDEX);

  logic [DATA_W-1:0] data_next;

  // shift / load selection
  always_comb begin
    data_next = data;
    if (ctrl.ins) begin
      if (MY_IDX == ctrl.idx) begin
        data_next = ctrl.value;
      end else if (MY_IDX > ctrl.idx) begin
        data_next = left_data;
      end
    end else if (ctrl.del) begin
      if (MY_IDX >= ctrl.idx) begin
        data_next = right_data;
      end
    end
  end

  // element register, payload only
  always_ff @(posedge clk) begin
    data <= data_next;
  end

  // key compare
  assign match = (data == ctrl.value);

endmodule

`default_nettype wire

### rtl/pal_chain.sv
// ----------------------------------------------------------------------------
// pal_chain
// Row of list cells; each cell is wired to its neighbors.
// ----------------------------------------------------------------------------
`default_nettype none

module pal_chain
  import pal_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEFAULT
) (
  input  wire logic                              clk,
  input  wire pal_cell_ctrl_t                    ctrl,
  output logic [CAPACITY-1:0][DATA_W-1:0]        data,
  output logic [CAPACITY-1:0]                    match
);

  // cell row with neighbor links; end cells feed back their own data
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_W-1:0] left_data;
    logic [DATA_W-1:0] right_data;

    if (i == 0) begin : g_first
      assign left_data = data[i];
    end else begin : g_mid_l
      assign left_data = data[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_data = data[i];
    end else begin : g_mid_r
      assign right_data = data[i+1];
    end

    pal_cell #(
      .INDEX (i)
    ) u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .left_data  (left_data),
      .right_data (right_data),
      .data       (data[i]),
      .match      (match[i])
    );
  end

endmodule

`default_nettype wire
